// ===== rtl/gws_pkg.sv =====
package gws_pkg;

   // Field widths of the item channels.
   localparam int CHR_BITS   = 8;
   localparam int POS_BITS   = 31;
   localparam int AC_BITS    = 28;
   localparam int ACC_BITS   = 32;
   localparam int VAR_BITS   = 25;
   localparam int FIRST_BITS = 25;
   localparam int END_BITS   = 26;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] REG_STRATEGY = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_TILE     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_VARIANTS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET   = 2'd3;

   // Windowing strategies; the fourth code behaves as the allele target.
   localparam logic [1:0] STRAT_TILE       = 2'd0;
   localparam logic [1:0] STRAT_COUNT      = 2'd1;
   localparam logic [1:0] STRAT_ALLELE     = 2'd2;
   localparam logic [1:0] STRAT_ALLELE_ALT = 2'd3;

   // Register values after reset.
   localparam logic [1:0]          RST_STRATEGY = STRAT_TILE;
   localparam logic [POS_BITS-1:0] RST_TILE     = 31'd100000;
   localparam logic [VAR_BITS-1:0] RST_VARIANTS = 25'd100;
   localparam logic [ACC_BITS-1:0] RST_TARGET   = 32'd16000;

   // One closed window as it leaves the block.
   typedef struct packed {
      logic [CHR_BITS-1:0]   window_chromosome;
      logic [FIRST_BITS-1:0] first_index;
      logic [END_BITS-1:0]   end_index;
      logic [POS_BITS-1:0]   start_bp;
      logic [POS_BITS-1:0]   end_bp;
   } gws_result_type;

   // Command to the remainder unit.
   typedef struct packed {
      logic                start;
      logic [POS_BITS-1:0] dividend;
      logic [POS_BITS-1:0] divisor;
   } gws_div_cmd_type;

   // Status from the remainder unit.
   typedef struct packed {
      logic                done;
      logic [POS_BITS-1:0] remainder;
   } gws_div_sts_type;

endpackage

// ===== rtl/gws_if.sv =====
// Variant record channel.
interface gws_req_if
   import gws_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CHR_BITS-1:0] chromosome;
   logic [POS_BITS-1:0] position;
   logic [AC_BITS-1:0]  allele_count;
   logic                count_known;
   logic                final_record;

   modport source (
      output valid, chromosome, position, allele_count, count_known, final_record,
      input  ready
   );
   modport sink (
      input  valid, chromosome, position, allele_count, count_known, final_record,
      output ready
   );
endinterface

// Closed window channel.
interface gws_rsp_if
   import gws_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CHR_BITS-1:0]   window_chromosome;
   logic [FIRST_BITS-1:0] first_index;
   logic [END_BITS-1:0]   end_index;
   logic [POS_BITS-1:0]   start_bp;
   logic [POS_BITS-1:0]   end_bp;
   logic                  last_of_run;

   modport source (
      output valid, window_chromosome, first_index, end_index, start_bp, end_bp,
             last_of_run,
      input  ready
   );
   modport sink (
      input  valid, window_chromosome, first_index, end_index, start_bp, end_bp,
             last_of_run,
      output ready
   );
endinterface

// Register write channel.
interface gws_csr_if
   import gws_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== rtl/genomic_window_segmenter.sv =====
// An accepted item passes the check and update states, and the divide state when a
// base-pair tile opens; the tile start comes from a 31-step remainder unit. Each
// closed window then waits for a free output register on rsp. One item is in flight
// at a time: a new item is taken only in the idle state.
// Reset is synchronous and active high: it clears the window state and loads the
// register defaults; no memory needs clearing.
module genomic_window_segmenter
   import gws_pkg::*;
#(
   parameter int INDEX_BITS = 25
) (
   input logic     clock,
   input logic     reset,
   gws_req_if.sink   req_chan,
   gws_rsp_if.source rsp_chan,
   gws_csr_if.sink   csr_chan
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_EMIT_A = 6'b010000,
      ST_EMIT_B = 6'b100000
   } gws_state_type;

   localparam logic [INDEX_BITS-1:0] IDX_ONE  = INDEX_BITS'(1);
   localparam logic [VAR_BITS-1:0]   VAR_ONE  = VAR_BITS'(1);
   localparam logic [VAR_BITS-1:0]   VAR_MAX  = '1;
   localparam logic [ACC_BITS-1:0]   ACC_MAX  = '1;
   localparam logic [POS_BITS-1:0]   POS_ONE  = POS_BITS'(1);
   localparam logic [POS_BITS-1:0]   POS_MAX  = '1;

   // Builds an outgoing window from index values of INDEX_BITS bits.
   function automatic gws_result_type make_result(
      input logic [CHR_BITS-1:0]   chr,
      input logic [INDEX_BITS-1:0] first,
      input logic [INDEX_BITS-1:0] last,
      input logic [POS_BITS-1:0]   start,
      input logic [POS_BITS-1:0]   stop
   );
      gws_result_type r;
      logic [63:0]    f64;
      logic [63:0]    e64;
      f64 = 64'(first);
      e64 = 64'(last) + 64'd1;
      r.window_chromosome = chr;
      r.first_index       = f64[FIRST_BITS-1:0];
      r.end_index         = e64[END_BITS-1:0];
      r.start_bp          = start;
      r.end_bp            = stop;
      return r;
   endfunction

   gws_state_type state_ff, state_in;

   // Configuration registers.
   logic [1:0]          strategy_ff;
   logic [POS_BITS-1:0] tile_ff;
   logic [VAR_BITS-1:0] variants_ff;
   logic [ACC_BITS-1:0] target_ff;

   // Latched item.
   logic [CHR_BITS-1:0]   chr_ff, chr_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [AC_BITS-1:0]    ac_ff, ac_in;
   logic                  fin_ff, fin_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;

   // Open window.
   logic                  open_ff, open_in;
   logic [CHR_BITS-1:0]   ochr_ff, ochr_in;
   logic [INDEX_BITS-1:0] ofirst_ff, ofirst_in;
   logic [INDEX_BITS-1:0] nidx_ff, nidx_in;
   logic [POS_BITS-1:0]   ostart_ff, ostart_in;
   logic [POS_BITS-1:0]   oend_ff, oend_in;
   logic [VAR_BITS-1:0]   nvar_ff, nvar_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;

   // Work of one item.
   logic                  need_open_ff, need_open_in;
   logic [POS_BITS-1:0]   tile_start_ff, tile_start_in;
   logic                  a_valid_ff, a_valid_in;
   logic                  b_valid_ff, b_valid_in;
   gws_result_type        pend_a_ff, pend_a_in;
   gws_result_type        pend_b_ff, pend_b_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   gws_result_type        rsp_data_ff, rsp_data_in;

   gws_div_cmd_type       div_cmd;
   gws_div_sts_type       div_sts;

   logic [1:0]            strat;
   logic [POS_BITS-1:0]   size_eff;
   logic [VAR_BITS-1:0]   lim;
   logic                  full_old;
   logic                  brk;
   logic [POS_BITS:0]     tile_last_sum;
   logic [POS_BITS-1:0]   tile_last;
   logic [ACC_BITS:0]     acc_sum;
   logic [CHR_BITS-1:0]   new_chr;
   logic [INDEX_BITS-1:0] new_first;
   logic [POS_BITS-1:0]   new_start;
   logic [POS_BITS-1:0]   new_end;
   logic [VAR_BITS-1:0]   new_nvar;
   logic [ACC_BITS-1:0]   new_acc;
   logic                  full_new;
   logic                  out_free;

   gws_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // Effective settings: zero sizes act as one, the spare code as the allele target.
   assign strat    = (strategy_ff == STRAT_ALLELE_ALT) ? STRAT_ALLELE : strategy_ff;
   assign size_eff = (tile_ff == '0) ? POS_ONE : tile_ff;
   assign lim      = (variants_ff == '0) ? VAR_ONE : variants_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Close test on the open window before the item joins it.
   always_comb begin
      full_old = 1'b0;
      if (strat == STRAT_COUNT) begin
         full_old = nvar_ff >= lim;
      end else if (strat == STRAT_ALLELE) begin
         full_old = acc_ff >= target_ff;
      end
      brk = open_ff && ((chr_ff != ochr_ff) || full_old ||
                        ((strat == STRAT_TILE) && (pos_ff > oend_ff)));
   end

   // Tile end, saturated at the top position.
   assign tile_last_sum = {1'b0, tile_start_ff} + {1'b0, size_eff} - {{POS_BITS{1'b0}}, 1'b1};
   assign tile_last     = tile_last_sum[POS_BITS] ? POS_MAX : tile_last_sum[POS_BITS-1:0];
   assign acc_sum       = {1'b0, acc_ff} + (ACC_BITS + 1)'(ac_ff);

   // Window state after the item joins, and the close test on it.
   always_comb begin
      if (need_open_ff) begin
         new_chr   = chr_ff;
         new_first = idx_ff;
         new_start = (strat == STRAT_TILE) ? tile_start_ff : pos_ff;
         new_end   = (strat == STRAT_TILE) ? tile_last : pos_ff;
         new_nvar  = VAR_ONE;
         new_acc   = ACC_BITS'(ac_ff);
      end else begin
         new_chr   = ochr_ff;
         new_first = ofirst_ff;
         new_start = ostart_ff;
         new_end   = (strat == STRAT_TILE) ? oend_ff : pos_ff;
         new_nvar  = (nvar_ff == VAR_MAX) ? nvar_ff : nvar_ff + VAR_ONE;
         new_acc   = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
      end
      full_new = 1'b0;
      if (strat == STRAT_COUNT) begin
         full_new = new_nvar >= lim;
      end else if (strat == STRAT_ALLELE) begin
         full_new = new_acc >= target_ff;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      chr_in        = chr_ff;
      pos_in        = pos_ff;
      ac_in         = ac_ff;
      fin_in        = fin_ff;
      idx_in        = idx_ff;
      open_in       = open_ff;
      ochr_in       = ochr_ff;
      ofirst_in     = ofirst_ff;
      nidx_in       = nidx_ff;
      ostart_in     = ostart_ff;
      oend_in       = oend_ff;
      nvar_in       = nvar_ff;
      acc_in        = acc_ff;
      need_open_in  = need_open_ff;
      tile_start_in = tile_start_ff;
      a_valid_in    = a_valid_ff;
      b_valid_in    = b_valid_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = pos_ff;
      div_cmd.divisor  = size_eff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               chr_in   = req_chan.chromosome;
               pos_in   = req_chan.position;
               ac_in    = req_chan.count_known ? req_chan.allele_count : '0;
               fin_in   = req_chan.final_record;
               idx_in   = nidx_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            a_valid_in   = brk;
            pend_a_in    = make_result(ochr_ff, ofirst_ff, idx_ff - IDX_ONE, ostart_ff, oend_ff);
            need_open_in = !open_ff || brk;
            if ((!open_ff || brk) && (strat == STRAT_TILE)) begin
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               tile_start_in = pos_ff - div_sts.remainder;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ochr_in    = new_chr;
            ofirst_in  = new_first;
            ostart_in  = new_start;
            oend_in    = new_end;
            nvar_in    = new_nvar;
            acc_in     = new_acc;
            nidx_in    = fin_ff ? '0 : idx_ff + IDX_ONE;
            b_valid_in = full_new || fin_ff;
            open_in    = !(full_new || fin_ff);
            pend_b_in  = make_result(new_chr, new_first, idx_ff, new_start, new_end);
            if (a_valid_ff) begin
               state_in = ST_EMIT_A;
            end else if (full_new || fin_ff) begin
               state_in = ST_EMIT_B;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_A: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_a_ff;
               rsp_last_in  = !b_valid_ff;
               state_in     = b_valid_ff ? ST_EMIT_B : ST_IDLE;
            end
         end
         ST_EMIT_B: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_b_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         ochr_ff      <= '0;
         ofirst_ff    <= '0;
         nidx_ff      <= '0;
         ostart_ff    <= '0;
         oend_ff      <= '0;
         nvar_ff      <= '0;
         acc_ff       <= '0;
         need_open_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         ochr_ff      <= ochr_in;
         ofirst_ff    <= ofirst_in;
         nidx_ff      <= nidx_in;
         ostart_ff    <= ostart_in;
         oend_ff      <= oend_in;
         nvar_ff      <= nvar_in;
         acc_ff       <= acc_in;
         need_open_ff <= need_open_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chr_ff        <= chr_in;
      pos_ff        <= pos_in;
      ac_ff         <= ac_in;
      fin_ff        <= fin_in;
      idx_ff        <= idx_in;
      tile_start_ff <= tile_start_in;
      pend_a_ff     <= pend_a_in;
      pend_b_ff     <= pend_b_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= RST_STRATEGY;
         tile_ff     <= RST_TILE;
         variants_ff <= RST_VARIANTS;
         target_ff   <= RST_TARGET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_STRATEGY: strategy_ff <= csr_chan.data[1:0];
            REG_TILE:     tile_ff     <= csr_chan.data[POS_BITS-1:0];
            REG_VARIANTS: variants_ff <= csr_chan.data[VAR_BITS-1:0];
            REG_TARGET:   target_ff   <= csr_chan.data[ACC_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.window_chromosome = rsp_data_ff.window_chromosome;
   assign rsp_chan.first_index       = rsp_data_ff.first_index;
   assign rsp_chan.end_index         = rsp_data_ff.end_index;
   assign rsp_chan.start_bp          = rsp_data_ff.start_bp;
   assign rsp_chan.end_bp            = rsp_data_ff.end_bp;
   assign rsp_chan.last_of_run       = rsp_last_ff;

endmodule

// ===== rtl/gws_rem_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle, POS_BITS steps.
module gws_rem_unit
   import gws_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  gws_div_cmd_type cmd,
   output gws_div_sts_type sts
);

   localparam int CNT_BITS = $clog2(POS_BITS + 1);
   localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(POS_BITS);
   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [POS_BITS:0]   rem_ff, rem_in;
   logic [POS_BITS-1:0] dvd_ff, dvd_in;
   logic [POS_BITS-1:0] dsr_ff, dsr_in;
   logic [POS_BITS:0]   trial;

   // One shift-and-subtract step.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[POS_BITS-1:0], dvd_ff[POS_BITS-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = STEPS;
         rem_in  = '0;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
         end else begin
            rem_in = trial;
         end
         dvd_in = {dvd_ff[POS_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_ONE;
         if (cnt_ff == CNT_ONE) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done      = done_ff;
   assign sts.remainder = rem_ff[POS_BITS-1:0];

endmodule
